// ----- hw/rtl/bsort_pkg.sv -----
// shared constants and helper functions for the bucket sorter
`default_nettype none

package bsort_pkg;

  localparam int BUCKETS         = 5;
  localparam int BUCKET_CAPACITY = 12;
  localparam int BUCKET_INTERVAL = 10;

  localparam int STORE_DEPTH = BUCKETS * BUCKET_CAPACITY;
  localparam int DATA_W      = 16;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BKT_W       = $clog2(BUCKETS);
  localparam int CNT_W       = $clog2(BUCKET_CAPACITY + 1);
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);

  // bucket index by comparison against constant thresholds, clamped at both ends
  function automatic logic [BKT_W-1:0] pick_bucket(input logic signed [DATA_W-1:0] v);
    logic [BKT_W-1:0] b;
    b = '0;
    for (int k = 1; k < BUCKETS; k++) begin
      if (int'(v) >= k * BUCKET_INTERVAL) begin
        b = BKT_W'(k);
      end
    end
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] bucket_base(input logic [BKT_W-1:0] b);
    return ADDR_W'(int'(b) * BUCKET_CAPACITY);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bucket_sorter.sv -----
// bucket sorter top level: insertion into bucket store and sorted emission
//
// input channel (in_valid, in_stall, in_value, in_last) takes one signed
// value per transaction. the value goes to a bucket chosen by value / interval,
// clamped to the first and last bucket, and is inserted in ascending order
// into a single-port-write, registered-read store. stored entries larger than
// the value move up through the registered read port, shifting one entry
// per cycle, before the value is written into the freed slot.
// a value whose bucket is full is dropped and sets the overflow flag.
// a transaction with in_last set starts emission once inserted or dropped: every
// stored value leaves on the result channel (out_valid, out_stall, out_value_res,
// out_last_res, out_overflow) in ascending order, out_last_res on the final one,
// out_overflow the same on all results of the frame. afterwards fill counts and
// the flag clear.
// in_stall is high whenever an insertion or emission is in progress.
// a result held by out_stall keeps its payload; emission waits for it.
// synchronous active-low reset clears fill counts, flag and control state;
// store contents need no clearing.
`default_nettype none

module bucket_sorter
  import bsort_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire signed [DATA_W-1:0] in_value,
  input  wire                     in_last,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic signed [DATA_W-1:0] out_value_res,
  output logic                    out_last_res,
  output logic                    out_overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_EMIT,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] mem [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_wa;
  logic signed [DATA_W-1:0] mem_wd;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_ra;

  logic [CNT_W-1:0] fill_r [BUCKETS];
  logic [CNT_W-1:0] fill_nxt [BUCKETS];
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             dropped_r, dropped_nxt;

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     last_r, last_nxt;
  logic [ADDR_W-1:0]        base_r, base_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;

  logic [BKT_W-1:0] eb_r, eb_nxt;
  logic [CNT_W-1:0] ek_r, ek_nxt;
  logic [TOT_W-1:0] cnt_r, cnt_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_ovf_r, out_ovf_nxt;

  logic [BKT_W-1:0] in_bkt;
  logic [BKT_W-1:0] fill_idx;
  logic [CNT_W-1:0] fill_rd;
  logic             accept;

  assign in_bkt   = pick_bucket(in_value);
  assign fill_idx = (state_r == S_IDLE) ? in_bkt : eb_r;
  assign fill_rd  = fill_r[fill_idx];
  assign accept   = in_valid && !in_stall;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;
  assign out_overflow  = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    dropped_nxt   = dropped_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    base_nxt      = base_r;
    k_nxt         = k_r;
    eb_nxt        = eb_r;
    ek_nxt        = ek_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_wa        = base_r + ADDR_W'(k_r);
    mem_wd        = val_r;
    mem_re        = 1'b0;
    mem_ra        = base_r + ADDR_W'(k_r) - ADDR_W'(2);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt  = in_value;
          last_nxt = in_last;
          base_nxt = bucket_base(in_bkt);
          k_nxt    = fill_rd;
          eb_nxt   = '0;
          ek_nxt   = '0;
          cnt_nxt  = '0;
          if (fill_rd >= CNT_W'(BUCKET_CAPACITY)) begin
            dropped_nxt = 1'b1;
            state_nxt   = in_last ? S_EMIT : S_IDLE;
          end else begin
            fill_nxt[in_bkt] = fill_rd + CNT_W'(1);
            total_nxt        = total_r + TOT_W'(1);
            if (fill_rd == '0) begin
              state_nxt = S_PLACE;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = bucket_base(in_bkt) + ADDR_W'(fill_rd) - ADDR_W'(1);
              state_nxt = S_CMP;
            end
          end
        end
      end

      S_CMP: begin
        mem_we = 1'b1;
        if (rd_data_r > val_r) begin
          mem_wd = rd_data_r;
          k_nxt  = k_r - CNT_W'(1);
          if (k_r == CNT_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            mem_re = 1'b1;
          end
        end else begin
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        state_nxt = last_r ? S_EMIT : S_IDLE;
      end

      S_EMIT: begin
        if (ek_r == fill_rd) begin
          if (eb_r == BKT_W'(BUCKETS - 1)) begin
            for (int b = 0; b < BUCKETS; b++) begin
              fill_nxt[b] = '0;
            end
            total_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            eb_nxt = eb_r + BKT_W'(1);
            ek_nxt = '0;
          end
        end else if (!out_valid_r || !out_stall) begin
          mem_re    = 1'b1;
          mem_ra    = bucket_base(eb_r) + ADDR_W'(ek_r);
          ek_nxt    = ek_r + CNT_W'(1);
          state_nxt = S_LOAD;
        end
      end

      S_LOAD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data_r;
        out_last_nxt  = (cnt_r + TOT_W'(1) == total_r);
        out_ovf_nxt   = dropped_r;
        cnt_nxt       = cnt_r + TOT_W'(1);
        state_nxt     = S_EMIT;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int b = 0; b < BUCKETS; b++) begin
        fill_r[b] <= '0;
      end
      total_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      eb_r        <= '0;
      ek_r        <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      eb_r        <= eb_nxt;
      ek_r        <= ek_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      last_r      <= last_nxt;
    end
    val_r       <= val_nxt;
    base_r      <= base_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule

`default_nettype wire

// ----- tb/tb_bucket_sorter.sv -----
// self-checking testbench for the bucket sorter: frames of signed values, sorted output checked
`timescale 1ns / 1ps

module tb_bucket_sorter;
  import bsort_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
    logic                     overflow;
  } sorted_item_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_t;

  class sort_scoreboard;
    logic signed [DATA_W-1:0] bucket_mem [BUCKETS][BUCKET_CAPACITY];
    int unsigned              fill_count [BUCKETS];
    bit                       frame_dropped;
    sorted_item_t             sorted_q [$];
    int unsigned              errors;
    int unsigned              frames;
    int unsigned              checked;
    int unsigned              dropped_values;
    int unsigned              clamped_values;

    function new();
      foreach (fill_count[b]) fill_count[b] = 0;
      frame_dropped  = 0;
      errors         = 0;
      frames         = 0;
      checked        = 0;
      dropped_values = 0;
      clamped_values = 0;
    endfunction

    function int unsigned bucket_of(logic signed [DATA_W-1:0] v);
      int q;
      q = int'(v) / BUCKET_INTERVAL;
      if (q < 0) begin
        clamped_values++;
        return 0;
      end
      if (q >= BUCKETS) begin
        clamped_values++;
        return BUCKETS - 1;
      end
      return q;
    endfunction

    function void note_input(logic signed [DATA_W-1:0] v, logic is_last);
      int unsigned b;
      int unsigned k;
      int unsigned total;
      int unsigned n;
      int unsigned i;
      int unsigned j;
      b = bucket_of(v);
      if (fill_count[b] >= BUCKET_CAPACITY) begin
        frame_dropped = 1;
        dropped_values++;
      end else begin
        k = fill_count[b];
        while (k > 0 && bucket_mem[b][k-1] > v) begin
          bucket_mem[b][k] = bucket_mem[b][k-1];
          k--;
        end
        bucket_mem[b][k] = v;
        fill_count[b]++;
      end
      if (is_last) begin
        total = 0;
        for (i = 0; i < BUCKETS; i++) total += fill_count[i];
        n = 0;
        for (i = 0; i < BUCKETS; i++) begin
          for (j = 0; j < fill_count[i]; j++) begin
            n++;
            sorted_q.push_back('{value: bucket_mem[i][j], is_last: (n == total),
                                 overflow: frame_dropped});
          end
        end
        for (i = 0; i < BUCKETS; i++) fill_count[i] = 0;
        frame_dropped = 0;
        frames++;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic signed [DATA_W-1:0] v, logic is_last, logic ovf);
      sorted_item_t exp_item;
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", v));
        return;
      end
      exp_item = sorted_q.pop_front();
      checked++;
      if (v !== exp_item.value)
        report_mismatch($sformatf("value %0d, wanted %0d", v, exp_item.value));
      if (is_last !== exp_item.is_last)
        report_mismatch($sformatf("last flag %b, wanted %b on value %0d",
                                  is_last, exp_item.is_last, exp_item.value));
      if (ovf !== exp_item.overflow)
        report_mismatch($sformatf("overflow %b, wanted %b on value %0d",
                                  ovf, exp_item.overflow, exp_item.value));
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_value_res;
  logic                     out_last_res;
  logic                     out_overflow;

  sort_scoreboard sb = new();

  int unsigned burst_left;
  int unsigned random_items;
  int unsigned stall_cycle = 0;
  stall_mode_t stall_mode = STALL_NONE;

  bucket_sorter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res),
    .out_overflow  (out_overflow)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // receiver stall pattern: no stall, random stalls or long stall bursts, mode picked at random
  always @(negedge clk) begin
    stall_cycle++;
    if (stall_cycle % 128 == 0) stall_mode = stall_mode_t'($urandom_range(0, 2));
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        out_stall <= ((stall_cycle % 24) < 15);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_value, in_last);
      if (out_valid && !out_stall) sb.check_result(out_value_res, out_last_res, out_overflow);
    end
  end

  task idle_cycles(int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task send_item(logic signed [DATA_W-1:0] v, logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) idle_cycles(gap);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= is_last;
    do @(posedge clk); while (in_stall);
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.sorted_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return DATA_W'(int'($urandom_range(0, 90)) - 20);
    if (sel < 8) return DATA_W'($urandom_range(0, 49));
    return DATA_W'($urandom);
  endfunction

  task send_frame(logic signed [DATA_W-1:0] vals [$]);
    int unsigned i;
    for (i = 0; i < vals.size(); i++) send_item(vals[i], i == vals.size() - 1);
  endtask

  initial begin
    int unsigned frame_len;
    int unsigned frame_no;
    int unsigned i;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_value    = '0;
    in_last     = 1'b0;
    burst_left  = 0;
    random_items = 0;
    frame_no    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single value frame
    send_frame('{16'sd0});
    // extremes, bucket edges and clamping at both ends
    send_frame('{16'sh7fff, 16'sh8000, 16'sd10, 16'sd9, -16'sd10, 16'sd50, 16'sd49});
    // full bucket with duplicates, last value dropped
    send_frame('{16'sd29, 16'sd20, 16'sd25, 16'sd25, 16'sd21, 16'sd28, 16'sd22,
                 16'sd27, 16'sd23, 16'sd26, 16'sd24, 16'sd20, 16'sd25});
    send_frame('{16'sd40, -16'sd1, 16'sd19, 16'sd39});

    while (random_items < 500) begin
      frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 20);
      for (i = 0; i < frame_len; i++) send_item(rand_value(), i == frame_len - 1);
      random_items += frame_len;
      frame_no++;
      // after the eighth frame, hold off until the output side has caught up
      if (frame_no == 8) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d frames, %0d sorted values checked", sb.frames, sb.checked);
    $display("%0d values dropped on full buckets, %0d clamped to an end bucket",
             sb.dropped_values, sb.clamped_values);
    if (sb.errors == 0 && sb.sorted_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.sorted_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bsort_pkg.sv
hw/rtl/bucket_sorter.sv
tb/tb_bucket_sorter.sv
